### src/sha_pkg.sv
package sha_pkg;

  localparam int unsigned CountW = 61;

  typedef logic [31:0] word_t;

  // request passed from front to back through the queue
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } req_t;

  localparam word_t HashInit [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundConst [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

### src/sha_if.sv
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       message_end;
  modport source (output valid, data_byte, byte_valid, message_end, input ready);
  modport sink (input valid, data_byte, byte_valid, message_end, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

### src/sha_fifo.sv
module sha_fifo import sha_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  req_t wdata_i,
  output logic full_o,
  input  logic pop_i,
  output req_t rdata_o,
  output logic empty_o
);
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  req_t          mem_q [Depth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0]   cnt_q;

  assign full_o  = (cnt_q == (AW+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) begin
        mem_q[wp_q] <= wdata_i;
        wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      end
      if (pop_i) rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(push_i) - (AW+1)'(pop_i);
    end
  end
endmodule

### src/sha_core.sv
module sha_core import sha_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  req_valid_i,
  input  req_t  req_i,
  output logic  req_pop_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output word_t out_word_o,
  output logic [2:0] out_idx_o
);
  typedef enum logic [2:0] {Idle, Pad, Len, Round, Emit} state_e;
  state_e state_q;

  word_t        blk_q [16];   // block buffer as 16 big-endian words
  word_t        w_q [16];
  word_t        v_q [8];
  word_t        h_q [8];
  logic [CountW-1:0] cnt_q;
  logic [5:0]   pos_q;        // pad write position
  logic [5:0]   rnd_q;
  logic         final_q;      // block being compressed closes the message
  logic         pad2_q;       // padding block follows the block being compressed
  logic         mark_q;       // 0x80 already placed for this message
  logic [2:0]   oidx_q;

  word_t wt, s1, ch, t1, s0, mj, sg0, sg1, wnew;
  logic [63:0] bit_len;

  assign bit_len = {cnt_q, 3'b000};
  assign out_valid_o = (state_q == Emit);
  assign out_word_o  = h_q[oidx_q];
  assign out_idx_o   = oidx_q;
  assign req_pop_o   = (state_q == Idle) && req_valid_i;

  always_comb begin
    sg0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
    sg1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
    wnew = w_q[0] + sg0 + w_q[9] + sg1;
    wt = (rnd_q < 6'd16) ? w_q[rnd_q[3:0]] : wnew;
    s1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
    ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1 = v_q[7] + s1 + ch + RoundConst[rnd_q] + wt;
    s0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
    mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
      cnt_q <= '0; rnd_q <= '0; pos_q <= '0; oidx_q <= '0;
      final_q <= 1'b0; pad2_q <= 1'b0; mark_q <= 1'b0;
      for (int j = 0; j < 8; j++) h_q[j] <= HashInit[j];
    end else begin
      case (state_q)
        Idle: if (req_valid_i) begin
          if (req_i.valid) begin
            blk_q[cnt_q[5:2]][8*(3-cnt_q[1:0]) +: 8] <= req_i.data;
            cnt_q <= cnt_q + 1'b1;
          end
          final_q <= 1'b0; mark_q <= 1'b0;
          if (req_i.valid && cnt_q[5:0] == 6'd63) begin
            pad2_q <= req_i.last; // remember end after this block
            state_q <= Round;
            for (int j = 0; j < 8; j++) v_q[j] <= h_q[j];
            for (int j = 0; j < 15; j++) w_q[j] <= blk_q[j];
            w_q[15] <= {blk_q[15][31:8], req_i.data};
            rnd_q <= '0;
          end else begin
            pad2_q <= 1'b0;
            if (req_i.last) begin
              pos_q <= req_i.valid ? cnt_q[5:0] + 6'd1 : cnt_q[5:0];
              state_q <= Pad;
            end
          end
        end
        Pad: begin
          // 0x80 goes at the first pad position of the message, zeros after
          blk_q[pos_q[5:2]][8*(3-pos_q[1:0]) +: 8] <= mark_q ? 8'h00 : 8'h80;
          mark_q <= 1'b1;
          if (pos_q == 6'd63) begin
            state_q <= Round;
            for (int j = 0; j < 8; j++) v_q[j] <= h_q[j];
            for (int j = 0; j < 15; j++) w_q[j] <= blk_q[j];
            w_q[15] <= {blk_q[15][31:8], mark_q ? 8'h00 : 8'h80};
            rnd_q <= '0; pos_q <= '0; final_q <= 1'b0;
            pad2_q <= 1'b1;
          end else if (pos_q == 6'd55) begin
            state_q <= Len;
          end else begin
            pos_q <= pos_q + 1'b1;
          end
        end
        Len: begin
          blk_q[14] <= bit_len[63:32];
          for (int j = 0; j < 8; j++) v_q[j] <= h_q[j];
          for (int j = 0; j < 14; j++) w_q[j] <= blk_q[j];
          w_q[14] <= bit_len[63:32];
          w_q[15] <= bit_len[31:0];
          rnd_q <= '0; final_q <= 1'b1;
          state_q <= Round;
        end
        Round: begin
          v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
          v_q[4] <= v_q[3] + t1;
          v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
          v_q[0] <= t1 + s0 + mj;
          if (rnd_q >= 6'd16) begin
            for (int j = 0; j < 15; j++) w_q[j] <= w_q[j+1];
            w_q[15] <= wnew;
          end else if (rnd_q == 6'd15) begin
            // window now holds W[0..15]; shifting starts at round 16
          end
          rnd_q <= rnd_q + 1'b1;
          if (rnd_q == 6'd63) begin
            h_q[0] <= h_q[0] + t1 + s0 + mj;
            h_q[1] <= h_q[1] + v_q[0]; h_q[2] <= h_q[2] + v_q[1];
            h_q[3] <= h_q[3] + v_q[2]; h_q[4] <= h_q[4] + v_q[3] + t1;
            h_q[5] <= h_q[5] + v_q[4]; h_q[6] <= h_q[6] + v_q[5];
            h_q[7] <= h_q[7] + v_q[6];
            if (final_q) begin
              state_q <= Emit; oidx_q <= '0;
            end else if (pad2_q) begin
              // another padding block follows
              pad2_q <= 1'b0; pos_q <= '0; state_q <= Pad;
            end else state_q <= Idle;
          end
        end
        Emit: if (out_ready_i) begin
          oidx_q <= oidx_q + 1'b1;
          if (oidx_q == 3'd7) begin
            for (int j = 0; j < 8; j++) h_q[j] <= HashInit[j];
            cnt_q <= '0;
            state_q <= Idle;
          end
        end
        default: state_q <= Idle;
      endcase
    end
  end
endmodule

### src/sha256_message_hasher_unit.sv
// SHA-256 message hasher.
// in_if: one request per message byte (byte_valid) with message_end marking
// the last request; an end request with byte_valid low closes the message
// without a byte, so the empty message hashes too.
// out_if: eight digest words, word_index 0..7, last_word on the eighth.
// A four-entry request queue decouples the input from the compression core.
// Each byte is written into the block buffer; a full block is then compressed
// in 64 rounds, during which the core takes no new requests. At message end
// the core pads (one pad byte at a time up to 56, then the length, 64 rounds,
// once or twice) and then presents the words one per cycle while ready is high.
// Whether one or two blocks are compressed after the end request depends on
// where the message stops within its block.
// If the receiver stalls the word holds and the core waits; the queue keeps
// taking requests until full.
// Reset clears the count, loads the initial hash and empties the queue.
module sha256_message_hasher_unit import sha_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input logic     clk_i,
  input logic     rst_ni,
  sha_in_if.sink    in_if,
  sha_out_if.source out_if
);
  req_t wreq, rreq;
  logic full, empty, pop;

  assign wreq = '{data: in_if.data_byte, valid: in_if.byte_valid,
                  last: in_if.message_end};
  assign in_if.ready = !full;

  sha_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i, .rst_ni,
    .push_i(in_if.valid && !full), .wdata_i(wreq), .full_o(full),
    .pop_i(pop), .rdata_o(rreq), .empty_o(empty)
  );

  sha_core u_core (
    .clk_i, .rst_ni,
    .req_valid_i(!empty), .req_i(rreq), .req_pop_o(pop),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .out_word_o(out_if.digest_word), .out_idx_o(out_if.word_index)
  );

  assign out_if.last_word = (out_if.word_index == 3'd7);
endmodule

### verif/sha256_message_hasher_unit_tb.sv
module sha256_message_hasher_unit_tb;
  import sha_pkg::*;

  localparam int unsigned StallLimit = 20000;

  typedef struct packed {
    word_t      word;
    logic [2:0] index;
    logic       last;
  } digest_item_t;

  // Software SHA-256 kept in step with the accepted requests.
  class digest_scoreboard;
    word_t                   hash_q [8];
    logic [7:0]              blk [64];
    logic [CountW-1:0]       count;
    digest_item_t            pending_words [$];
    int unsigned             errors;
    int unsigned             digests;
    int unsigned             words_checked;

    function new();
      hash_q = HashInit;
      count = '0;
      errors = 0;
      digests = 0;
      words_checked = 0;
    endfunction

    function word_t ror(word_t x, int unsigned n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      word_t w [16];
      word_t v [8];
      word_t s0, s1, t1, t2, ch, mj, w15, w2;
      for (int t = 0; t < 16; t++) begin
        w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
      end
      v = hash_q;
      for (int t = 0; t < 64; t++) begin
        if (t >= 16) begin
          w15 = w[(t-15) & 15];
          w2 = w[(t-2) & 15];
          w[t & 15] = w[t & 15] + (ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3))
                      + w[(t-7) & 15] + (ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10));
        end
        s1 = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
        ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
        t1 = v[7] + s1 + ch + RoundConst[t] + w[t & 15];
        s0 = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
        mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
        t2 = s0 + mj;
        v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
        v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int j = 0; j < 8; j++) hash_q[j] += v[j];
    endfunction

    function void note_request(logic [7:0] data, logic bv, logic fin);
      int unsigned pos;
      logic [63:0] bits;
      digest_item_t it;
      if (bv) begin
        pos = count[5:0];
        blk[pos] = data;
        count = count + 1'b1;
        if (pos == 63) compress();
      end
      if (!fin) return;
      pos = count[5:0];
      blk[pos] = 8'h80;
      pos++;
      if (pos > 56) begin
        while (pos < 64) begin blk[pos] = 8'h00; pos++; end
        compress();
        pos = 0;
      end
      while (pos < 56) begin blk[pos] = 8'h00; pos++; end
      bits = {count, 3'b000};
      for (int k = 0; k < 8; k++) blk[56+k] = bits[63-8*k -: 8];
      compress();
      for (int k = 0; k < 8; k++) begin
        it.word = hash_q[k];
        it.index = 3'(k);
        it.last = (k == 7);
        pending_words = {pending_words, it};
      end
      hash_q = HashInit;
      count = '0;
      digests++;
    endfunction

    function void check_word(word_t word, logic [2:0] index, logic last);
      digest_item_t e;
      if (pending_words.size() == 0) begin
        $error("digest word %h with nothing pending", word);
        errors++;
        return;
      end
      e = pending_words.pop_front();
      words_checked++;
      if (word !== e.word) begin
        $error("digest_word: expected %h, got %h", e.word, word); errors++;
      end
      if (index !== e.index) begin
        $error("word_index: expected %0d, got %0d", e.index, index); errors++;
      end
      if (last !== e.last) begin
        $error("last_word: expected %0b, got %0b", e.last, last); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  sha_in_if  in_if ();
  sha_out_if out_if ();

  sha256_message_hasher_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  digest_scoreboard sb = new();
  int unsigned idle_cycles = 0;
  int unsigned sent = 0;
  bit calm = 1'b0;
  bit sink_stall = 1'b0;

  initial begin
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.byte_valid = 1'b0;
    in_if.message_end = 1'b0;
    out_if.ready = 1'b0;
  end

  // Sampling at the rising edge: check words, record requests, watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        sb.note_request(in_if.data_byte, in_if.byte_valid, in_if.message_end);
      end
      if (out_if.valid && out_if.ready) begin
        sb.check_word(out_if.digest_word, out_if.word_index, out_if.last_word);
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("timeout with %0d words pending", sb.pending_words.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts until the calm phase.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (calm) begin
        out_if.ready <= 1'b1;
      end else if (sink_stall) begin
        sink_stall = 1'b0;
        out_if.ready <= 1'b0;
        n = $urandom_range(14, 1);
        repeat (n - 1) @(negedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        n = $urandom_range(20, 1);
        repeat (n - 1) begin
          @(negedge clk_i);
          if (calm) break;
        end
        sink_stall = 1'b1;
      end
    end
  end

  task automatic send_req(logic [7:0] data, logic bv, logic fin);
    if (!calm && $urandom_range(9, 0) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(14, 1)) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data_byte <= data;
    in_if.byte_valid <= bv;
    in_if.message_end <= fin;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic send_message(int unsigned len, bit end_with_byte, int unsigned pattern);
    logic [7:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      case (pattern)
        0: b = 8'h00;
        1: b = 8'hff;
        default: b = 8'($urandom);
      endcase
      send_req(b, 1'b1, end_with_byte && (i == len - 1));
      // occasional no-op request after a byte of a message
      if (!calm && $urandom_range(30, 0) == 0) send_req(8'($urandom), 1'b0, 1'b0);
    end
    if (!end_with_byte || len == 0) send_req(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending_words.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    int unsigned len;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty message, no-op request, one byte with end, pad edges.
    send_req(8'h5a, 1'b0, 1'b0);
    send_message(0, 1'b0, 2);
    send_message(1, 1'b1, 1);
    send_message(3, 1'b0, 0);
    send_message(2, 1'b1, 2);
    drain();
    send_message(55, 1'b1, 2);
    send_message(56, 1'b0, 1);
    send_message(63, 1'b1, 2);
    send_message(64, 1'b0, 2);
    // sender waits for the results before carrying on
    drain();
    send_message(65, 1'b1, 2);

    while (sent < 360) begin
      len = ($urandom_range(3, 0) == 0) ? $urandom_range(130, 50) : $urandom_range(12, 0);
      if (sent > 300) calm = 1'b1;
      send_message(len, 1'($urandom_range(1, 0)), $urandom_range(5, 0) == 0 ? 1 : 2);
    end
    calm = 1'b1;
    drain();
    repeat (300) @(negedge clk_i);
    $display("hashed %0d messages, %0d requests; %0d digest words compared",
             sb.digests, sent, sb.words_checked);
    if (sb.errors == 0 && sb.pending_words.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
src/sha_pkg.sv
src/sha_if.sv
src/sha_fifo.sv
src/sha_core.sv
src/sha256_message_hasher_unit.sv
verif/sha256_message_hasher_unit_tb.sv
